>>> src/vertex_trs_transform_top_defines.svh
// Assertion macros for the vertex transform block.
// Used by vertex_trs_transform_top; depends on nothing else.
`ifndef VERTEX_TRS_TRANSFORM_TOP_DEFINES_SVH
`define VERTEX_TRS_TRANSFORM_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define VTT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vtt check failed");

// Next-cycle implication, checked outside reset.
`define VTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vtt check failed");

`endif

>>> src/vtt_pkg.sv
// Shared types, constants and helper functions for the vertex transform.
// No dependencies.
`timescale 1ns / 1ps

package vtt_pkg;

    localparam int AngleBits = 16;
    localparam int AngleDrop = (AngleBits < 16) ? 16 - AngleBits : 0;
    localparam logic [15:0] AngleMask = 16'(32'h0000_FFFF << AngleDrop);

    localparam int CordicSteps = 30;
    localparam logic signed [33:0] CordicStart = 34'sd652032874;
    localparam logic signed [33:0] CordicLim = 34'sd1073741824;
    localparam logic [31:0] OneQ30 = 32'h4000_0000;
    localparam logic [31:0] OneQ24 = 32'h0100_0000;

    typedef logic [31:0] t_word;
    typedef t_word t_mat [9];

    typedef enum logic [2:0] {
        CfgMoveX   = 3'd0,
        CfgMoveY   = 3'd1,
        CfgMoveZ   = 3'd2,
        CfgTurn    = 3'd3,
        CfgStretch = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic        start;
        logic [47:0] turn;
        logic [47:0] stretch;
    } t_seq_req;

    // atan(2^-i) in binary-angle units, 2^32 = one turn
    function automatic logic [31:0] f_atan(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] f_sat32(input logic signed [65:0] v);
        logic [31:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -66'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [15:0] f_sat16(input logic signed [65:0] v);
        logic [15:0] r;
        if (v > 66'sd32767) begin
            r = 16'h7FFF;
        end else if (v < -66'sd32768) begin
            r = 16'h8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

>>> src/vtt_in_if.sv
// Vertex input channel: valid/ready plus position and normal fields.
// No dependencies.
`timescale 1ns / 1ps

interface vtt_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] in_px;
    logic [31:0] in_py;
    logic [31:0] in_pz;
    logic [15:0] in_nx;
    logic [15:0] in_ny;
    logic [15:0] in_nz;

    modport source (output valid, in_px, in_py, in_pz, in_nx, in_ny, in_nz, input ready);
    modport sink   (input valid, in_px, in_py, in_pz, in_nx, in_ny, in_nz, output ready);
endinterface

>>> src/vtt_out_if.sv
// Vertex result channel: valid/ready plus transformed position and normal.
// No dependencies.
`timescale 1ns / 1ps

interface vtt_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_px;
    logic [31:0] out_py;
    logic [31:0] out_pz;
    logic [15:0] out_nx;
    logic [15:0] out_ny;
    logic [15:0] out_nz;

    modport source (output valid, out_px, out_py, out_pz, out_nx, out_ny, out_nz,
                    input ready);
    modport sink   (input valid, out_px, out_py, out_pz, out_nx, out_ny, out_nz,
                    output ready);
endinterface

>>> src/vtt_cfg_if.sv
// Configuration write channel: valid/ready, register index and data.
// No dependencies.
`timescale 1ns / 1ps

interface vtt_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [47:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> src/vtt_cordic.sv
// Iterative CORDIC sine/cosine, one rotation step per cycle, Q2.30 out.
// Depends on vtt_pkg.
`timescale 1ns / 1ps

module vtt_cordic (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_angle,
    output logic        o_done,
    output logic [31:0] o_cos,
    output logic [31:0] o_sin
);

    logic               r_busy;
    logic [4:0]         r_step;
    logic signed [33:0] r_x, r_y, r_z;
    logic [1:0]         r_q;
    logic               r_done;
    logic [31:0]        r_cos, r_sin;

    logic [31:0]        phase, phase_bias, ru;
    logic [1:0]         quad;
    logic signed [33:0] xs, ys, at, n_x, n_y, n_z;
    logic [31:0]        xc, yc, n_cos, n_sin;

    // reduce to within 45 degrees of a quadrant axis
    always_comb begin
        phase      = {i_angle & vtt_pkg::AngleMask, 16'h0000};
        phase_bias = phase + 32'h2000_0000;
        quad       = phase_bias[31:30];
        ru         = phase - {quad, 30'd0};
    end

    always_comb begin
        xs = r_x >>> r_step;
        ys = r_y >>> r_step;
        at = 34'(vtt_pkg::f_atan(r_step));
        if (r_z >= 0) begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - at;
        end else begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + at;
        end
        if (n_x > vtt_pkg::CordicLim) begin
            xc = vtt_pkg::OneQ30;
        end else if (n_x < -vtt_pkg::CordicLim) begin
            xc = -vtt_pkg::OneQ30;
        end else begin
            xc = n_x[31:0];
        end
        if (n_y > vtt_pkg::CordicLim) begin
            yc = vtt_pkg::OneQ30;
        end else if (n_y < -vtt_pkg::CordicLim) begin
            yc = -vtt_pkg::OneQ30;
        end else begin
            yc = n_y[31:0];
        end
        case (r_q)
            2'd0: begin
                n_cos = xc;
                n_sin = yc;
            end
            2'd1: begin
                n_cos = -yc;
                n_sin = xc;
            end
            2'd2: begin
                n_cos = -xc;
                n_sin = -yc;
            end
            default: begin
                n_cos = yc;
                n_sin = -xc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_step <= '0;
                r_x    <= vtt_pkg::CordicStart;
                r_y    <= '0;
                r_z    <= 34'(signed'(ru));
                r_q    <= quad;
            end else if (r_busy) begin
                r_x    <= n_x;
                r_y    <= n_y;
                r_z    <= n_z;
                r_step <= r_step + 5'd1;
                if (r_step == 5'(vtt_pkg::CordicSteps - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_cos  <= n_cos;
                    r_sin  <= n_sin;
                end else begin
                    r_done <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_cos;
    assign o_sin  = r_sin;

endmodule

>>> src/vtt_mat_seq.sv
// Matrix rebuild sequencer: three CORDIC runs, Ry*Rx, (Ry*Rx)*Rz, then R*S,
// on one shared multiply-accumulate. Depends on vtt_pkg and vtt_cordic.
`timescale 1ns / 1ps

module vtt_mat_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  vtt_pkg::t_seq_req i_req,
    output logic              o_busy,
    output vtt_pkg::t_mat     o_rot,
    output vtt_pkg::t_mat     o_model
);

    typedef enum logic [2:0] {
        S_IDLE, S_ANG, S_WAIT, S_MUL, S_ACC, S_SCL, S_SCW
    } t_state;

    t_state             r_state;
    logic [1:0]         r_ang, r_i, r_j, r_k;
    logic               r_mat;
    logic [31:0]        r_cp, r_sp, r_cy, r_sy, r_cr, r_sr;
    vtt_pkg::t_mat      r_t, r_rot, r_model;
    logic signed [63:0] r_prod;
    logic signed [65:0] r_acc;

    logic [15:0]        ang;
    logic               cd_done;
    logic [31:0]        cd_cos, cd_sin;
    logic [3:0]         idx_a, idx_b, idx_o;
    logic [31:0]        ry_e, rx_e, rz_e, op_a, op_b;
    logic [15:0]        sc16;
    logic signed [65:0] acc_n, mq, sq;

    always_comb begin
        case (r_ang)
            2'd0:    ang = i_req.turn[15:0];
            2'd1:    ang = i_req.turn[31:16];
            default: ang = i_req.turn[47:32];
        endcase
    end

    vtt_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_ANG),
        .i_angle (ang),
        .o_done  (cd_done),
        .o_cos   (cd_cos),
        .o_sin   (cd_sin)
    );

    always_comb begin
        idx_a = 4'(r_i) * 4'd3 + 4'(r_k);
        idx_b = 4'(r_k) * 4'd3 + 4'(r_j);
        idx_o = 4'(r_i) * 4'd3 + 4'(r_j);
        case (idx_a)
            4'd0:    ry_e = r_cy;
            4'd2:    ry_e = r_sy;
            4'd4:    ry_e = vtt_pkg::OneQ30;
            4'd6:    ry_e = -r_sy;
            4'd8:    ry_e = r_cy;
            default: ry_e = '0;
        endcase
        case (idx_b)
            4'd0:    rx_e = vtt_pkg::OneQ30;
            4'd4:    rx_e = r_cp;
            4'd5:    rx_e = -r_sp;
            4'd7:    rx_e = r_sp;
            4'd8:    rx_e = r_cp;
            default: rx_e = '0;
        endcase
        case (idx_b)
            4'd0:    rz_e = r_cr;
            4'd1:    rz_e = -r_sr;
            4'd3:    rz_e = r_sr;
            4'd4:    rz_e = r_cr;
            4'd8:    rz_e = vtt_pkg::OneQ30;
            default: rz_e = '0;
        endcase
        case (r_j)
            2'd0:    sc16 = i_req.stretch[15:0];
            2'd1:    sc16 = i_req.stretch[31:16];
            default: sc16 = i_req.stretch[47:32];
        endcase
        if (r_state == S_SCL) begin
            op_a = r_rot[idx_o];
            op_b = {{16{sc16[15]}}, sc16};
        end else if (r_mat) begin
            op_a = r_t[idx_a];
            op_b = rz_e;
        end else begin
            op_a = ry_e;
            op_b = rx_e;
        end
        acc_n = r_acc + 66'(r_prod);
        mq    = (acc_n + 66'sd536870912) >>> 30;
        sq    = (66'(r_prod) + 66'sd8192) >>> 14;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ang   <= '0;
            r_mat   <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_acc   <= '0;
            for (int e = 0; e < 9; e++) begin
                r_rot[e]   <= (e % 4 == 0) ? vtt_pkg::OneQ30 : '0;
                r_model[e] <= (e % 4 == 0) ? vtt_pkg::OneQ24 : '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_ang   <= '0;
                        r_mat   <= 1'b0;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_k     <= '0;
                        r_acc   <= '0;
                        r_state <= S_ANG;
                    end
                end
                S_ANG: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (cd_done) begin
                        case (r_ang)
                            2'd0: begin
                                r_cp <= cd_cos;
                                r_sp <= cd_sin;
                            end
                            2'd1: begin
                                r_cy <= cd_cos;
                                r_sy <= cd_sin;
                            end
                            default: begin
                                r_cr <= cd_cos;
                                r_sr <= cd_sin;
                            end
                        endcase
                        if (r_ang == 2'd2) begin
                            r_state <= S_MUL;
                        end else begin
                            r_ang   <= r_ang + 2'd1;
                            r_state <= S_ANG;
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= signed'(op_a) * signed'(op_b);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_k == 2'd2) begin
                        // entry complete: round to Q2.30 and store
                        if (r_mat) begin
                            r_rot[idx_o] <= vtt_pkg::f_sat32(mq);
                        end else begin
                            r_t[idx_o] <= vtt_pkg::f_sat32(mq);
                        end
                        r_k   <= '0;
                        r_acc <= '0;
                        if (r_j == 2'd2) begin
                            r_j <= '0;
                            if (r_i == 2'd2) begin
                                r_i <= '0;
                                if (r_mat) begin
                                    r_state <= S_SCL;
                                end else begin
                                    r_mat   <= 1'b1;
                                    r_state <= S_MUL;
                                end
                            end else begin
                                r_i     <= r_i + 2'd1;
                                r_state <= S_MUL;
                            end
                        end else begin
                            r_j     <= r_j + 2'd1;
                            r_state <= S_MUL;
                        end
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_acc   <= acc_n;
                        r_state <= S_MUL;
                    end
                end
                S_SCL: begin
                    r_prod  <= signed'(op_a) * signed'(op_b);
                    r_state <= S_SCW;
                end
                S_SCW: begin
                    r_model[idx_o] <= vtt_pkg::f_sat32(sq);
                    if (r_j == 2'd2) begin
                        r_j <= '0;
                        if (r_i == 2'd2) begin
                            r_i     <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_i     <= r_i + 2'd1;
                            r_state <= S_SCL;
                        end
                    end else begin
                        r_j     <= r_j + 2'd1;
                        r_state <= S_SCL;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_rot   = r_rot;
    assign o_model = r_model;

endmodule

>>> src/vtt_xform.sv
// Vertex datapath: input register, product register, result register.
// Depends on vtt_pkg, vtt_in_if and vtt_out_if.
`timescale 1ns / 1ps

module vtt_xform (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_hold,
    input  vtt_pkg::t_mat i_rot,
    input  vtt_pkg::t_mat i_model,
    input  logic [31:0]   i_move_x,
    input  logic [31:0]   i_move_y,
    input  logic [31:0]   i_move_z,
    vtt_in_if.sink        i_in,
    vtt_out_if.source     o_out
);

    logic               r_v0, r_v1, r_v2;
    logic [31:0]        r_p [3];
    logic [15:0]        r_n [3];
    logic signed [63:0] r_pp [9];
    logic signed [47:0] r_np [9];
    logic [31:0]        r_op [3];
    logic [15:0]        r_on [3];

    logic               en0, en1, en2, take;
    logic [31:0]        mv [3];
    logic signed [65:0] psum [3], nsum [3];
    logic [31:0]        n_op [3];
    logic [15:0]        n_on [3];

    assign en2  = !r_v2 || o_out.ready;
    assign en1  = !r_v1 || en2;
    assign en0  = !r_v0 || en1;
    assign take = i_in.valid && en0 && !i_hold;
    assign i_in.ready = en0 && !i_hold;

    assign mv[0] = i_move_x;
    assign mv[1] = i_move_y;
    assign mv[2] = i_move_z;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            psum[r] = 66'(signed'(mv[r]));
            nsum[r] = '0;
            for (int c = 0; c < 3; c++) begin
                psum[r] = psum[r] + ((66'(r_pp[r * 3 + c]) + 66'sd8388608) >>> 24);
                nsum[r] = nsum[r] + 66'(r_np[r * 3 + c]);
            end
            n_op[r] = vtt_pkg::f_sat32(psum[r]);
            n_on[r] = vtt_pkg::f_sat16((nsum[r] + 66'sd536870912) >>> 30);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en0) begin
                r_v0 <= take;
            end
            if (en1) begin
                r_v1 <= r_v0;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_p[0] <= i_in.in_px;
            r_p[1] <= i_in.in_py;
            r_p[2] <= i_in.in_pz;
            r_n[0] <= i_in.in_nx;
            r_n[1] <= i_in.in_ny;
            r_n[2] <= i_in.in_nz;
        end
        if (en1 && r_v0) begin
            for (int e = 0; e < 9; e++) begin
                r_pp[e] <= signed'(i_model[e]) * signed'(r_p[e % 3]);
                r_np[e] <= 48'(signed'(i_rot[e]) * signed'(r_n[e % 3]));
            end
        end
        if (en2 && r_v1) begin
            r_op <= n_op;
            r_on <= n_on;
        end
    end

    assign o_out.valid  = r_v2;
    assign o_out.out_px = r_op[0];
    assign o_out.out_py = r_op[1];
    assign o_out.out_pz = r_op[2];
    assign o_out.out_nx = r_on[0];
    assign o_out.out_ny = r_on[1];
    assign o_out.out_nz = r_on[2];

endmodule

>>> src/vertex_trs_transform_top.sv
// Vertex transform top level: each vertex passes the input, product and result registers
// of vtt_xform. Throughput: one item per cycle when the result side is ready and no
// rebuild is running; a stall holds a stage only while it and every later stage are full.
// Configuration write to a listed register: ready drops after the accepting edge until
// the rebuild ends (launch register, three CORDIC runs, 2 x 27 MACs, 9 scale steps).
// Reset (synchronous, i_rst_n low): pipeline empty, moves zero, scale 1.0, R, M identity.
`timescale 1ns / 1ps
`include "vertex_trs_transform_top_defines.svh"

module vertex_trs_transform_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vtt_in_if.sink    i_in,
    vtt_out_if.source o_out,
    vtt_cfg_if.sink   i_cfg
);

    // configuration registers
    logic [31:0]       r_move_x, r_move_y, r_move_z;
    logic [47:0]       r_turn, r_stretch;
    logic              r_start;

    logic              cfg_take, idx_ok, seq_busy, busy;
    vtt_pkg::t_seq_req seq_req;
    vtt_pkg::t_mat     rot, model;

    // hold off items and writes while the matrices are rebuilt
    assign busy        = seq_busy || r_start;
    assign i_cfg.ready = !busy;
    assign cfg_take    = i_cfg.valid && i_cfg.ready;
    assign idx_ok      = (i_cfg.index == vtt_pkg::CfgMoveX) ||
                         (i_cfg.index == vtt_pkg::CfgMoveY) ||
                         (i_cfg.index == vtt_pkg::CfgMoveZ) ||
                         (i_cfg.index == vtt_pkg::CfgTurn)  ||
                         (i_cfg.index == vtt_pkg::CfgStretch);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_move_x  <= '0;
            r_move_y  <= '0;
            r_move_z  <= '0;
            r_turn    <= '0;
            r_stretch <= 48'h0100_0100_0100;
            r_start   <= 1'b0;
        end else begin
            // register the rebuild launch together with the write
            r_start <= cfg_take && idx_ok;
            if (cfg_take) begin
                case (i_cfg.index)
                    vtt_pkg::CfgMoveX:   r_move_x  <= i_cfg.data[31:0];
                    vtt_pkg::CfgMoveY:   r_move_y  <= i_cfg.data[31:0];
                    vtt_pkg::CfgMoveZ:   r_move_z  <= i_cfg.data[31:0];
                    vtt_pkg::CfgTurn:    r_turn    <= i_cfg.data;
                    vtt_pkg::CfgStretch: r_stretch <= i_cfg.data;
                    default: begin
                        // drop writes outside the register list
                    end
                endcase
            end
        end
    end

    assign seq_req.start   = r_start;
    assign seq_req.turn    = r_turn;
    assign seq_req.stretch = r_stretch;

    vtt_mat_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (seq_req),
        .o_busy  (seq_busy),
        .o_rot   (rot),
        .o_model (model)
    );

    vtt_xform u_xform (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_hold   (busy),
        .i_rot    (rot),
        .i_model  (model),
        .i_move_x (r_move_x),
        .i_move_y (r_move_y),
        .i_move_z (r_move_z),
        .i_in     (i_in),
        .o_out    (o_out)
    );

    // no item enters while the matrices are being rebuilt
    `VTT_ASSERT_NOW(a_no_item_busy, i_clk, i_rst_n, i_in.valid && i_in.ready, !busy)
    // a write to a listed register always starts a rebuild
    `VTT_ASSERT_NEXT(a_write_starts, i_clk, i_rst_n, cfg_take && idx_ok, busy)
    // the sequencer only runs after a launch
    `VTT_ASSERT_NEXT(a_seq_launch, i_clk, i_rst_n, !seq_busy && !r_start, !seq_busy)

endmodule
